// ===== design/e2q_pkg.sv =====
// Package for the Euler-angle to quaternion pipeline.
// Holds the fixed-point widths, the CORDIC constants and the arctangent table.
// Depends on nothing.
package e2q_pkg;

  localparam int AngleW  = 16;
  localparam int QuatW   = 16;
  localparam int HalfW   = 17;
  localparam int Steps   = 30;
  localparam int CordW   = 34;
  localparam int TrigW   = 22;
  localparam int PairW   = 2 * TrigW;
  localparam int SplitW  = 22;
  localparam int TripW   = 64;
  localparam int Lanes   = 3;

  localparam logic signed [HalfW-1:0] HalfTurn    = 17'sd23040;
  localparam logic signed [HalfW-1:0] QuarterTurn = 17'sd11520;
  localparam logic signed [18:0]      AngleScale  = 19'sd146409;
  localparam logic signed [CordW-1:0] GainInv     = 34'sd652032874;
  localparam logic signed [QuatW-1:0] QuatOne     = 16'sd16384;

  localparam logic signed [CordW-1:0] AtanQ30 [Steps] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
  };

  // Latency in cycles from an accepted start to the done strobe.
  localparam int Latency = Steps + 7;

endpackage

// ===== design/euler_to_quaternion.sv =====
// Top level of the Euler-angle to quaternion pipeline: fold, CORDIC, products.
// Depends on e2q_pkg.
//
// Channel | Direction | Handshake      | Payload
// command | in        | start_i/busy_o | pitch_angle_i, yaw_angle_i, roll_angle_i
// result  | out       | done_o         | quat_real_o, quat_i_o, quat_j_o, quat_k_o
//
// One item is accepted in every cycle; busy_o is always low.
// Each result passes through one fold stage, one angle scaling stage, thirty
// CORDIC stages and five product and rounding stages.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so the pipeline never holds.
module euler_to_quaternion (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [e2q_pkg::AngleW-1:0]   pitch_angle_i,
  input  logic signed [e2q_pkg::AngleW-1:0]   yaw_angle_i,
  input  logic signed [e2q_pkg::AngleW-1:0]   roll_angle_i,
  output logic                                done_o,
  output logic signed [e2q_pkg::QuatW-1:0]    quat_real_o,
  output logic signed [e2q_pkg::QuatW-1:0]    quat_i_o,
  output logic signed [e2q_pkg::QuatW-1:0]    quat_j_o,
  output logic signed [e2q_pkg::QuatW-1:0]    quat_k_o
);
  import e2q_pkg::*;

  // Pair and sine/cosine selection for the eight triple products.
  localparam int PairSel [8] = '{0, 1, 2, 3, 3, 2, 0, 1};
  localparam bit UseSin  [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  function automatic logic signed [QuatW-1:0] finish(input logic signed [TripW-1:0] s);
    logic signed [TripW-1:0] q;
    q = (s + (64'sd1 <<< 45)) >>> 46;
    if (q > TripW'(QuatOne)) begin
      q = TripW'(QuatOne);
    end else if (q < -TripW'(QuatOne)) begin
      q = -TripW'(QuatOne);
    end
    return q[QuatW-1:0];
  endfunction

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Stage 1: wrap and fold the half angles.
  logic signed [AngleW-1:0] ang [Lanes];
  logic signed [HalfW-1:0]  fold_d [Lanes];
  logic                     neg_d [Lanes];
  logic signed [HalfW-1:0]  fold_q [Lanes];
  logic                     neg1_q [Lanes];
  logic                     v1_q;

  assign ang[0] = pitch_angle_i;
  assign ang[1] = yaw_angle_i;
  assign ang[2] = roll_angle_i;

  always_comb begin
    logic signed [HalfW-1:0] h;
    for (int l = 0; l < Lanes; l++) begin
      h = HalfW'(ang[l]);
      if (h >= HalfTurn) begin
        h = h - (HalfTurn <<< 1);
      end else if (h < -HalfTurn) begin
        h = h + (HalfTurn <<< 1);
      end
      neg_d[l] = 1'b0;
      if (h > QuarterTurn) begin
        h = HalfTurn - h;
        neg_d[l] = 1'b1;
      end else if (h < -QuarterTurn) begin
        h = -HalfTurn - h;
        neg_d[l] = 1'b1;
      end
      fold_d[l] = h;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
    neg1_q <= neg_d;
  end

  // Stage 2 and the CORDIC stages: index 0 holds the scaled angle.
  logic signed [CordW-1:0] cx_q [Lanes][Steps+1];
  logic signed [CordW-1:0] cy_q [Lanes][Steps+1];
  logic signed [CordW-1:0] cz_q [Lanes][Steps+1];
  logic                    cn_q [Lanes][Steps+1];
  logic [Steps:0]          cv_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      cx_q[l][0] <= GainInv;
      cy_q[l][0] <= '0;
      cz_q[l][0] <= CordW'(fold_q[l] * AngleScale);
      cn_q[l][0] <= neg1_q[l];
      for (int i = 0; i < Steps; i++) begin
        if (!cz_q[l][i][CordW-1]) begin
          cx_q[l][i+1] <= cx_q[l][i] - (cy_q[l][i] >>> i);
          cy_q[l][i+1] <= cy_q[l][i] + (cx_q[l][i] >>> i);
          cz_q[l][i+1] <= cz_q[l][i] - AtanQ30[i];
        end else begin
          cx_q[l][i+1] <= cx_q[l][i] + (cy_q[l][i] >>> i);
          cy_q[l][i+1] <= cy_q[l][i] - (cx_q[l][i] >>> i);
          cz_q[l][i+1] <= cz_q[l][i] + AtanQ30[i];
        end
        cn_q[l][i+1] <= cn_q[l][i];
      end
    end
  end

  // Rounding to Q20 and the cosine sign.
  logic signed [TrigW-1:0] cos_q [Lanes];
  logic signed [TrigW-1:0] sin_q [Lanes];
  logic                    vr_q;

  always_ff @(posedge clk_i) begin
    logic signed [CordW-1:0] rx;
    logic signed [CordW-1:0] ry;
    for (int l = 0; l < Lanes; l++) begin
      rx = (cx_q[l][Steps] + 34'sd512) >>> 10;
      ry = (cy_q[l][Steps] + 34'sd512) >>> 10;
      cos_q[l] <= cn_q[l][Steps] ? -rx[TrigW-1:0] : rx[TrigW-1:0];
      sin_q[l] <= ry[TrigW-1:0];
    end
  end

  // Pitch-yaw pairs; roll sine and cosine ride along.
  logic signed [PairW-1:0] pair_q [4];
  logic signed [TrigW-1:0] cr_q;
  logic signed [TrigW-1:0] sr_q;
  logic                    vp_q;

  always_ff @(posedge clk_i) begin
    pair_q[0] <= cos_q[0] * cos_q[1];
    pair_q[1] <= sin_q[0] * sin_q[1];
    pair_q[2] <= sin_q[0] * cos_q[1];
    pair_q[3] <= cos_q[0] * sin_q[1];
    cr_q      <= cos_q[2];
    sr_q      <= sin_q[2];
  end

  // Each pair times a roll term is split into two partial products.
  logic signed [PairW-1:0]   hi_q [8];
  logic signed [PairW:0]     lo_q [8];
  logic signed [TripW-1:0]   trip_q [8];
  logic                      vh_q;
  logic                      vt_q;

  always_ff @(posedge clk_i) begin
    logic signed [TrigW-1:0]  r;
    logic signed [SplitW-1:0] ph;
    logic signed [SplitW:0]   pl;
    for (int t = 0; t < 8; t++) begin
      r  = UseSin[t] ? sr_q : cr_q;
      ph = pair_q[PairSel[t]][PairW-1:SplitW];
      pl = $signed({1'b0, pair_q[PairSel[t]][SplitW-1:0]});
      hi_q[t] <= ph * r;
      lo_q[t] <= pl * r;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 8; t++) begin
      trip_q[t] <= (TripW'(hi_q[t]) <<< SplitW) + TripW'(lo_q[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    quat_real_o <= finish(trip_q[0] + trip_q[1]);
    quat_i_o    <= finish(trip_q[2] - trip_q[3]);
    quat_j_o    <= finish(trip_q[4] + trip_q[5]);
    quat_k_o    <= finish(trip_q[6] - trip_q[7]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      cv_q   <= '0;
      vr_q   <= 1'b0;
      vp_q   <= 1'b0;
      vh_q   <= 1'b0;
      vt_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= accept;
      cv_q   <= {cv_q[Steps-1:0], v1_q};
      vr_q   <= cv_q[Steps];
      vp_q   <= vr_q;
      vh_q   <= vp_q;
      vt_q   <= vh_q;
      done_o <= vt_q;
    end
  end

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted item did not complete after the pipeline latency");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_real_o <= QuatOne && quat_real_o >= -QuatOne &&
                quat_k_o <= QuatOne && quat_k_o >= -QuatOne))
    else $error("quaternion component outside saturation range");

  a_cordic_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> cv_q[0])
    else $error("valid bit lost entering the CORDIC stages");

endmodule

// ===== tb/tb_euler_to_quaternion.sv =====
// Self-checking testbench for the Euler-angle to quaternion pipeline.
// Predicts each quaternion with its own CORDIC and product arithmetic; depends on e2q_pkg.
`timescale 1ns / 1ps

module tb_euler_to_quaternion;
  import e2q_pkg::*;

  typedef struct packed {
    logic signed [QuatW-1:0] re;
    logic signed [QuatW-1:0] qi;
    logic signed [QuatW-1:0] qj;
    logic signed [QuatW-1:0] qk;
  } quat_t;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleBoth
  } idle_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic signed [AngleW-1:0] pitch_angle_i;
  logic signed [AngleW-1:0] yaw_angle_i;
  logic signed [AngleW-1:0] roll_angle_i;
  logic                     done_o;
  logic signed [QuatW-1:0]  quat_real_o;
  logic signed [QuatW-1:0]  quat_i_o;
  logic signed [QuatW-1:0]  quat_j_o;
  logic signed [QuatW-1:0]  quat_k_o;

  quat_t      pending_quats[$];
  int         error_count;
  int         item_count;
  int         result_count;
  idle_mode_e idle_mode;

  // Coefficients of the arctangent steps, kept as 64-bit values.
  longint atan_steps[30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  euler_to_quaternion dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .pitch_angle_i(pitch_angle_i),
    .yaw_angle_i  (yaw_angle_i),
    .roll_angle_i (roll_angle_i),
    .done_o       (done_o),
    .quat_real_o  (quat_real_o),
    .quat_i_o     (quat_i_o),
    .quat_j_o     (quat_j_o),
    .quat_k_o     (quat_k_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Cosine and sine of half the given angle, both in Q20.
  task automatic half_angle_trig(input logic signed [AngleW-1:0] angle,
                                 output longint cos_q20, output longint sin_q20);
    longint h;
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip_cos;
    h = angle;
    flip_cos = 1'b0;
    x = 652032874;
    y = 0;
    if (h >= 23040) h -= 46080;
    else if (h < -23040) h += 46080;
    if (h > 11520) begin
      h = 23040 - h;
      flip_cos = 1'b1;
    end else if (h < -11520) begin
      h = -23040 - h;
      flip_cos = 1'b1;
    end
    z = h * 146409;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_steps[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_steps[i];
      end
      x = nx;
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    cos_q20 = flip_cos ? -x : x;
    sin_q20 = y;
  endtask

  // The sums of Q60 triple products stay inside 64 bits.
  function automatic logic signed [QuatW-1:0] round_to_q14(input longint sum);
    longint q;
    q = (sum + (64'sd1 <<< 45)) >>> 46;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[QuatW-1:0];
  endfunction

  task automatic predict_quaternion(input logic signed [AngleW-1:0] pitch,
                                    input logic signed [AngleW-1:0] yaw,
                                    input logic signed [AngleW-1:0] roll,
                                    output quat_t q);
    longint cp, sp, cy, sy, cr, sr;
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(yaw, cy, sy);
    half_angle_trig(roll, cr, sr);
    q.re = round_to_q14(cr * cp * cy + sr * sp * sy);
    q.qi = round_to_q14(cr * sp * cy - sr * cp * sy);
    q.qj = round_to_q14(cr * cp * sy + sr * sp * cy);
    q.qk = round_to_q14(sr * cp * cy - cr * sp * sy);
  endtask

  // Sends one set of angles; the transfer completes at the edge where busy_o is low.
  task automatic send_angles(input logic signed [AngleW-1:0] pitch,
                             input logic signed [AngleW-1:0] yaw,
                             input logic signed [AngleW-1:0] roll);
    quat_t q;
    int    gap_pct;
    gap_pct = (idle_mode == IdleSender) ? 64 : (idle_mode == IdleBoth) ? 23 : 0;
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    pitch_angle_i <= pitch;
    yaw_angle_i   <= yaw;
    roll_angle_i  <= roll;
    predict_quaternion(pitch, yaw, roll, q);
    do @(posedge clk_i); while (busy_o);
    pending_quats.push_back(q);
    item_count++;
  endtask

  task automatic end_burst();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    end_burst();
    while (pending_quats.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    quat_t got;
    quat_t want;
    if (rst_ni && done_o) begin
      got = '{quat_real_o, quat_i_o, quat_j_o, quat_k_o};
      result_count++;
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d %0d", $time,
                 got.re, got.qi, got.qj, got.qk);
        error_count++;
      end else begin
        want = pending_quats.pop_front();
        if (got.re !== want.re) begin
          $display("%0t: quat_real expected %0d actual %0d", $time, want.re, got.re);
          error_count++;
        end
        if (got.qi !== want.qi) begin
          $display("%0t: quat_i expected %0d actual %0d", $time, want.qi, got.qi);
          error_count++;
        end
        if (got.qj !== want.qj) begin
          $display("%0t: quat_j expected %0d actual %0d", $time, want.qj, got.qj);
          error_count++;
        end
        if (got.qk !== want.qk) begin
          $display("%0t: quat_k expected %0d actual %0d", $time, want.qk, got.qk);
          error_count++;
        end
      end
    end
  end

  // Range extremes, the fold boundaries and the wrap points of the half angle.
  task automatic test_directed_angles();
    logic signed [AngleW-1:0] corners[12] = '{
      16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1, 16'sd23040, -16'sd23040,
      16'sd23041, -16'sd23041, 16'sd11520, -16'sd11520, 16'sd5760
    };
    idle_mode = IdleNone;
    for (int i = 0; i < 12; i++)
      send_angles(corners[i], corners[(i + 4) % 12], corners[(i + 7) % 12]);
    send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sd0, 16'sd0, 16'sd0);
    send_angles(16'sd11520, 16'sd0, 16'sd0);
    send_angles(16'sd0, 16'sd11520, 16'sd0);
    send_angles(16'sd0, 16'sd0, 16'sd11520);
    send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
    send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
    // Hold off until the pipeline has emptied before moving on.
    wait_drained();
  endtask

  // Mostly full-range angles, with some near the fold and wrap points and some at the range extremes.
  function automatic logic signed [AngleW-1:0] pick_angle();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return AngleW'($urandom());
    if (sel == 7) return 16'sd23040 + $signed(16'($urandom_range(8) - 4));
    if (sel == 8) return -16'sd11520 + $signed(16'($urandom_range(8) - 4));
    return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  task automatic test_random_angles(input idle_mode_e mode, input int count);
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      send_angles(pick_angle(), pick_angle(), pick_angle());
      if ($urandom_range(15) == 0) end_burst();
    end
    wait_drained();
  endtask

  initial begin
    error_count   = 0;
    item_count    = 0;
    result_count  = 0;
    idle_mode     = IdleNone;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    pitch_angle_i = '0;
    yaw_angle_i   = '0;
    roll_angle_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_angles();
    test_random_angles(IdleNone, 400);
    test_random_angles(IdleSender, 350);
    test_random_angles(IdleBoth, 400);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Sent %0d angle triples, checked %0d quaternions, over three idling phases.",
             item_count, result_count);
    if (error_count == 0 && pending_quats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding.", pending_quats.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
